>>> src/sws_pkg.sv
// shared types and constants for the sorting stack
// no dependencies; imported by stack_with_sort
`default_nettype none

package sws_pkg;

	// field widths of the command and result transfers
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int COUNT_W   = 7;

	// default number of entries in each store
	localparam int STACK_DEPTH_DEF = 64;

	// value returned by pop or top on an empty stack
	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_TOP  = 2'd2,
		CMD_SORT = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_POP,
		S_LOAD,
		S_CMP,
		S_BACK
	} state_t;

endpackage

`default_nettype wire

>>> src/stack_with_sort.sv
// bounded lifo stack of signed 32-bit values with an in-place sort command
// depends on sws_pkg for widths, command and status codes and sequencer states
`default_nettype none

// Each command transfer gives exactly one result transfer. Push, and pop or top
// on an empty stack, finish in the accept cycle; pop and top on a non-empty
// stack also pass S_READ, as the stack memory has one registered read port.
// Sort moves the n held values through a scratch memory one at a time with a
// single signed comparator: each value taken off the stack passes S_POP,
// S_LOAD and S_CMP, S_CMP shifts larger scratch values back one at a time (at
// most n*(n-1)/2 in total), and S_BACK returns scratch values one at a time.
// The input stalls while a command is in progress and while an undelivered
// result is held in the output register by out_stall. The memories need no
// clearing after reset; only entries below the fill levels are ever read.
module stack_with_sort
	import sws_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [CMD_W-1:0]          command,
	input  wire logic signed [DATA_W-1:0]  push_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [DATA_W-1:0]       read_value,
	output logic [STAT_W-1:0]              status,
	output logic [COUNT_W-1:0]             entry_count
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

	// sequencer and level registers
	state_t                state_q, state_d;
	logic [CW-1:0]         fill_q, fill_d;
	logic [CW-1:0]         scr_q, scr_d;
	logic [DATA_W-1:0]     held_q, held_d;

	// memories and their ports
	logic [DATA_W-1:0]     stk_mem [STACK_DEPTH];
	logic [DATA_W-1:0]     scr_mem [STACK_DEPTH];
	logic                  stk_we, stk_re, scr_we, scr_re;
	logic [AW-1:0]         stk_wa, stk_ra, scr_wa, scr_ra;
	logic [DATA_W-1:0]     stk_wd, scr_wd;
	logic [DATA_W-1:0]     stk_rd_q, scr_rd_q;

	// output register
	logic                  out_valid_q;
	logic [DATA_W-1:0]     read_value_q;
	logic [STAT_W-1:0]     status_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  out_load;
	logic [DATA_W-1:0]     out_rd;
	stat_t                 out_st;

	logic                  in_xfer;
	logic [CW-1:0]         fill_m1, scr_m1, scr_m2;
	logic [XW-1:0]         fill_ext;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;
	assign fill_m1  = fill_q - CW'(1);
	assign scr_m1   = scr_q - CW'(1);
	assign scr_m2   = scr_q - CW'(2);
	assign fill_ext = XW'(fill_d);

	// next state, level updates and memory controls
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		scr_d    = scr_q;
		held_d   = held_q;
		stk_we   = 1'b0;
		stk_wa   = fill_q[AW-1:0];
		stk_wd   = scr_rd_q;
		stk_re   = 1'b0;
		stk_ra   = fill_m1[AW-1:0];
		scr_we   = 1'b0;
		scr_wa   = scr_q[AW-1:0];
		scr_wd   = held_q;
		scr_re   = 1'b0;
		scr_ra   = scr_m1[AW-1:0];
		out_load = 1'b0;
		out_rd   = '0;
		out_st   = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (cmd_t'(command))
						CMD_PUSH: begin
							out_load = 1'b1;
							if (fill_q < CW'(STACK_DEPTH)) begin
								stk_we = 1'b1;
								stk_wd = push_value;
								fill_d = fill_q + CW'(1);
							end else begin
								out_st = STAT_FULL;
							end
						end
						CMD_POP, CMD_TOP: begin
							if (fill_q != '0) begin
								stk_re  = 1'b1;
								state_d = S_READ;
								if (cmd_t'(command) == CMD_POP) begin
									fill_d = fill_m1;
								end
							end else begin
								out_load = 1'b1;
								out_rd   = EMPTY_VALUE;
								out_st   = STAT_EMPTY;
							end
						end
						CMD_SORT: begin
							scr_d   = '0;
							state_d = S_POP;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			// registered read data of pop or top is ready
			S_READ: begin
				out_load = 1'b1;
				out_rd   = stk_rd_q;
				state_d  = S_IDLE;
			end
			// take the next value off the stack, fetch the scratch top alongside, or return scratch once empty
			S_POP: begin
				if (fill_q != '0) begin
					fill_d  = fill_m1;
					stk_re  = 1'b1;
					scr_re  = (scr_q != '0);
					state_d = S_LOAD;
				end else if (scr_q != '0) begin
					scr_re  = 1'b1;
					state_d = S_BACK;
				end else begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LOAD: begin
				held_d  = stk_rd_q;
				state_d = S_CMP;
			end
			// shift larger scratch values back to the stack, then insert held value
			S_CMP: begin
				if (scr_q != '0 && $signed(scr_rd_q) > $signed(held_q)) begin
					stk_we = 1'b1;
					fill_d = fill_q + CW'(1);
					scr_d  = scr_m1;
					scr_re = (scr_q > CW'(1));
					scr_ra = scr_m2[AW-1:0];
				end else begin
					scr_we  = 1'b1;
					scr_d   = scr_q + CW'(1);
					state_d = S_POP;
				end
			end
			// return scratch contents so the smallest ends on top
			S_BACK: begin
				stk_we = 1'b1;
				fill_d = fill_q + CW'(1);
				scr_d  = scr_m1;
				if (scr_q > CW'(1)) begin
					scr_re = 1'b1;
					scr_ra = scr_m2[AW-1:0];
				end else begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			scr_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			scr_q   <= scr_d;
			held_q  <= held_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			read_value_q <= out_rd;
			status_q     <= out_st;
			count_q      <= fill_ext[COUNT_W-1:0];
		end
	end

	// stack memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	// scratch memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_wa] <= scr_wd;
		end
		if (scr_re) begin
			scr_rd_q <= scr_mem[scr_ra];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

`default_nettype wire
